>>> rtl/fqs_pkg.sv
package fqs_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 5;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-beat control that every cell in the row sees.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

>>> rtl/fqs_cell.sv
module fqs_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fqs_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [fqs_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_prev_valid,
    input  logic signed [fqs_pkg::VALUE_W-1:0] i_next_data,
    input  logic                              i_next_valid,
    output logic signed [fqs_pkg::VALUE_W-1:0] o_data,
    output logic                              o_valid,
    output logic                              o_match
);

    logic signed [fqs_pkg::VALUE_W-1:0] r_data;
    logic                               r_valid;
    logic                               write_here;

    // The first empty cell after the occupied run takes a pushed value.
    // A full row has no such cell, so a push on full drops by itself.
    assign write_here = i_ctrl.push && !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_valid <= i_next_valid;
        end else if (write_here) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_data <= i_next_data;
        end else if (write_here) begin
            r_data <= i_value;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_data == i_value);

endmodule

>>> rtl/fifo_queue_with_search.sv
// Bounded first-in first-out queue of signed 32-bit values with a key search.
// Input channel: i_valid / o_stall carry one command per beat (i_command,
// i_value): push the value at the tail, pop the head, or search for the value
// among the stored entries. Command code 3 changes nothing.
// Output channel: o_valid / i_stall carry exactly one result beat per command:
// head and tail values after the command (zero when empty), the entry count,
// the found flag of a search, and a status (ok, push dropped on full, pop on
// empty).
// The entries live in a row of DEPTH cells, head in cell 0. A pop shifts
// every cell one place toward the head; a push fills the first empty cell.
// Every cell compares its entry against the key, so a search needs no scan.
// A result beat is registered and shows in the cycle after its command is
// accepted; a command enters every cycle while the receiver takes results.
// While a result waits under i_stall, o_stall is high and no command enters.
// Reset empties the queue and drops any pending result beat.
module fifo_queue_with_search #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fqs_pkg::CMD_W-1:0]           i_command,
    input  logic signed [fqs_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fqs_pkg::VALUE_W-1:0]  o_front_value,
    output logic signed [fqs_pkg::VALUE_W-1:0]  o_back_value,
    output logic [fqs_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_found,
    output logic [fqs_pkg::STATUS_W-1:0]        o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                                accept;
    fqs_pkg::t_cell_ctrl                 ctrl;
    logic signed [fqs_pkg::VALUE_W-1:0]  cell_data  [DEPTH];
    logic [DEPTH-1:0]                    cell_valid;
    logic [DEPTH-1:0]                    cell_match;

    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic signed [fqs_pkg::VALUE_W-1:0]  r_back;
    logic signed [fqs_pkg::VALUE_W-1:0]  n_back;
    logic                                full;
    logic                                empty;
    logic                                is_search;
    fqs_pkg::t_status                    status;
    logic signed [fqs_pkg::VALUE_W-1:0]  front;
    logic [31:0]                         count_ext;

    logic                                r_out_valid;
    logic signed [fqs_pkg::VALUE_W-1:0]  r_front_value;
    logic signed [fqs_pkg::VALUE_W-1:0]  r_back_value;
    logic [fqs_pkg::COUNT_W-1:0]         r_entry_count;
    logic                                r_found;
    logic [fqs_pkg::STATUS_W-1:0]        r_status;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        ctrl      = '0;
        status    = fqs_pkg::ST_OK;
        is_search = 1'b0;
        n_count   = r_count;
        n_back    = r_back;
        unique case (i_command)
            fqs_pkg::CMD_PUSH: begin
                if (full) begin
                    status = fqs_pkg::ST_FULL;
                end else begin
                    ctrl.push = accept;
                    n_count   = r_count + 1'b1;
                    n_back    = i_value;
                end
            end
            fqs_pkg::CMD_POP: begin
                if (empty) begin
                    status = fqs_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop = accept;
                    n_count  = r_count - 1'b1;
                end
            end
            fqs_pkg::CMD_SEARCH: begin
                is_search = 1'b1;
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                               prev_valid;
            logic signed [fqs_pkg::VALUE_W-1:0] next_data;
            logic                               next_valid;

            if (g == 0) begin : g_first
                assign prev_valid = 1'b1;
            end else begin : g_mid
                assign prev_valid = cell_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_data  = '0;
                assign next_valid = 1'b0;
            end else begin : g_inner
                assign next_data  = cell_data[g+1];
                assign next_valid = cell_valid[g+1];
            end

            fqs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_value      (i_value),
                .i_prev_valid (prev_valid),
                .i_next_data  (next_data),
                .i_next_valid (next_valid),
                .o_data       (cell_data[g]),
                .o_valid      (cell_valid[g]),
                .o_match      (cell_match[g])
            );
        end
    endgenerate

    // Head value after this beat, taken from the cells before they update.
    always_comb begin
        if (n_count == '0) begin
            front = '0;
        end else if (ctrl.pop) begin
            front = cell_data[1];
        end else if (ctrl.push && empty) begin
            front = i_value;
        end else begin
            front = cell_data[0];
        end
    end

    assign count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_back        <= n_back;
            r_front_value <= front;
            r_back_value  <= (n_count == '0) ? '0 : n_back;
            r_entry_count <= count_ext[fqs_pkg::COUNT_W-1:0];
            r_found       <= is_search && (|cell_match);
            r_status      <= status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_front_value = r_front_value;
    assign o_back_value  = r_back_value;
    assign o_entry_count = r_entry_count;
    assign o_found       = r_found;
    assign o_status      = r_status;

endmodule

>>> rtl/fqs_checker.sv
module fqs_checker #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [fqs_pkg::VALUE_W-1:0]  o_front_value,
    input logic signed [fqs_pkg::VALUE_W-1:0]  o_back_value,
    input logic [fqs_pkg::COUNT_W-1:0]         o_entry_count,
    input logic                                o_found,
    input logic [fqs_pkg::STATUS_W-1:0]        o_status
);

    localparam int FULL_SEEN = DEPTH % (1 << fqs_pkg::COUNT_W);

    // An empty queue shows zero at both ends.
    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_count == '0) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty queue shows a nonzero end value");

    // A dropped push leaves the queue full.
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fqs_pkg::ST_FULL) |-> (32'(o_entry_count) == FULL_SEEN))
        else $error("push dropped while the queue was not full");

    // A pop on empty leaves the queue empty.
    a_empty_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fqs_pkg::ST_EMPTY) |-> (o_entry_count == '0 && !o_found))
        else $error("pop on empty with entries present");

    // A stalled result beat holds.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_front_value) && $stable(o_status)))
        else $error("stalled result beat changed");

endmodule

bind fifo_queue_with_search fqs_checker #(
    .DEPTH (DEPTH)
) u_fqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_entry_count (o_entry_count),
    .o_found       (o_found),
    .o_status      (o_status)
);
